[hdl/tcl_pkg.sv]
// Shared types, constants and helper functions for the token class lexer.
package tcl_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int PAYLOAD_W       = 16;
    localparam int BYTE_W          = 8;
    localparam int CLASS_W         = 4;
    localparam int M_TDATA_W       = 40;

    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
    localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z    = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIG_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIG_9   = 8'h39;

    typedef enum logic [CLASS_W-1:0] {
        CLS_CELL    = 4'd0,
        CLS_PHASE   = 4'd1,
        CLS_FEED    = 4'd2,
        CLS_HOOK    = 4'd3,
        CLS_CHOOK   = 4'd4,
        CLS_DKEY    = 4'd5,
        CLS_IKEY    = 4'd6,
        CLS_MAP     = 4'd7,
        CLS_INCLUDE = 4'd8,
        CLS_INVALID = 4'd9,
        CLS_NONE    = 4'd10
    } tok_class_t;

    // Flag bits: [0] tail alnum, [1] all upper, [2] all lower, [3] all letters
    typedef struct packed {
        logic [BYTE_W-1:0] first_char;
        logic [BYTE_W-1:0] last_char;
        logic [3:0]        flags;
        logic [1:0]        kw_miss;   // [0] HOOK ruled out, [1] CHOOK ruled out
        logic              cnt_is1;
        logic              cnt_is4;
        logic              cnt_is5;
        logic              cnt_gt1;
    } tok_sum_t;

    typedef struct packed {
        tok_class_t cls;
        logic       skip;   // payload starts one byte in
        logic [1:0] trim;   // bytes removed from the length
    } cls_res_t;

    function automatic logic [BYTE_W-1:0] hook_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd0:    c = 8'h48;  // H
            2'd1:    c = 8'h4F;  // O
            2'd2:    c = 8'h4F;  // O
            default: c = 8'h4B;  // K
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] chook_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h43;  // C
            3'd1:    c = 8'h48;  // H
            3'd2:    c = 8'h4F;  // O
            3'd3:    c = 8'h4F;  // O
            default: c = 8'h4B;  // K
        endcase
        return c;
    endfunction

endpackage

[hdl/tcl_track.sv]
// Token tracker: byte position, pending token summary and sticky flags.
module tcl_track #(
    parameter int OFFSET_BITS = tcl_pkg::OFFSET_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  logic [tcl_pkg::BYTE_W-1:0] byte_in,
    input  logic                       last_in,
    input  logic                       tok_invalid,
    output tcl_pkg::tok_sum_t          tok_sum,
    output logic [OFFSET_BITS-1:0]     begin_after,
    output logic [OFFSET_BITS-1:0]     count_after,
    output logic                       closing,
    output logic                       sticky_err,
    output logic                       ovf_flag
);
    import tcl_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]      first_reg, first_next;
    logic [BYTE_W-1:0]      last_reg,  last_next;
    logic [3:0]             flags_reg, flags_next;
    logic [1:0]             kw_reg,    kw_next;
    logic                   err_reg,   err_next;
    logic                   ovf_reg,   ovf_next;

    logic              is_sep, up, lo, al, an, idx0, at_max;
    logic [BYTE_W-1:0] first_a, last_a;
    logic [3:0]        flags_a;
    logic [1:0]        kw_a;

    always_comb begin
        is_sep = (byte_in == CH_SPACE) || (byte_in == CH_NL);
        up     = (byte_in >= CH_UP_A) && (byte_in <= CH_UP_Z);
        lo     = (byte_in >= CH_LO_A) && (byte_in <= CH_LO_Z);
        al     = up || lo;
        an     = al || ((byte_in >= CH_DIG_0) && (byte_in <= CH_DIG_9));
        idx0   = (count_reg == '0);
        at_max = (pos_reg == OFF_MAX);

        if (is_sep) begin
            begin_after = begin_reg;
            count_after = count_reg;
            first_a     = first_reg;
            last_a      = last_reg;
            flags_a     = flags_reg;
            kw_a        = kw_reg;
        end else begin
            begin_after = idx0 ? pos_reg : begin_reg;
            first_a     = idx0 ? byte_in : first_reg;
            last_a      = byte_in;
            count_after = (count_reg == OFF_MAX) ? count_reg : count_reg + 1'b1;
            flags_a[0]  = flags_reg[0] & (idx0 | an);
            flags_a[1]  = flags_reg[1] & up;
            flags_a[2]  = flags_reg[2] & lo;
            flags_a[3]  = flags_reg[3] & al;
            kw_a[0]     = kw_reg[0] | (count_reg >= OFFSET_BITS'(4))
                        | (hook_char(count_reg[1:0]) != byte_in);
            kw_a[1]     = kw_reg[1] | (count_reg >= OFFSET_BITS'(5))
                        | (chook_char(count_reg[2:0]) != byte_in);
        end

        closing = (is_sep || last_in) && (count_after != '0);

        tok_sum.first_char = first_a;
        tok_sum.last_char  = last_a;
        tok_sum.flags      = flags_a;
        tok_sum.kw_miss    = kw_a;
        tok_sum.cnt_is1    = (count_after == OFFSET_BITS'(1));
        tok_sum.cnt_is4    = (count_after == OFFSET_BITS'(4));
        tok_sum.cnt_is5    = (count_after == OFFSET_BITS'(5));
        tok_sum.cnt_gt1    = (count_after > OFFSET_BITS'(1));

        sticky_err = err_reg | (closing && tok_invalid);
        ovf_flag   = ovf_reg | at_max;

        pos_next   = pos_reg;
        begin_next = begin_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        flags_next = flags_reg;
        kw_next    = kw_reg;
        err_next   = err_reg;
        ovf_next   = ovf_reg;
        if (fire) begin
            if (last_in || closing) begin
                begin_next = '0;
                count_next = '0;
                first_next = '0;
                last_next  = '0;
                flags_next = 4'hF;
                kw_next    = '0;
            end else begin
                begin_next = begin_after;
                count_next = count_after;
                first_next = first_a;
                last_next  = last_a;
                flags_next = flags_a;
                kw_next    = kw_a;
            end
            if (last_in) begin
                pos_next = '0;
                err_next = 1'b0;
                ovf_next = 1'b0;
            end else begin
                pos_next = at_max ? OFF_MAX : pos_reg + 1'b1;
                err_next = sticky_err;
                ovf_next = ovf_flag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            begin_reg <= '0;
            count_reg <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            flags_reg <= 4'hF;
            kw_reg    <= '0;
            err_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            count_reg <= count_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            flags_reg <= flags_next;
            kw_reg    <= kw_next;
            err_reg   <= err_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[hdl/tcl_classify.sv]
// Token classifier: priority decode of a closed token's summary.
module tcl_classify (
    input  tcl_pkg::tok_sum_t tok_sum,
    output tcl_pkg::cls_res_t res
);
    import tcl_pkg::*;

    logic tail_an, all_up, all_lo, all_al;

    always_comb begin
        tail_an = tok_sum.flags[0];
        all_up  = tok_sum.flags[1];
        all_lo  = tok_sum.flags[2];
        all_al  = tok_sum.flags[3];

        res.cls  = CLS_INVALID;
        res.skip = 1'b0;
        res.trim = 2'd0;
        if (tok_sum.first_char == CH_DOLLAR && tail_an) begin
            res.cls  = CLS_CELL;
            res.skip = 1'b1;
            res.trim = 2'd1;
        end else if (tok_sum.cnt_is1 && (tok_sum.first_char inside {[CH_UP_A:CH_UP_Z]})) begin
            res.cls = CLS_PHASE;
        end else if (tok_sum.first_char == CH_LBRACK && tok_sum.last_char == CH_RBRACK) begin
            res.cls  = CLS_FEED;
            res.skip = 1'b1;
            res.trim = 2'd2;
        end else if (tok_sum.cnt_is4 && !tok_sum.kw_miss[0]) begin
            res.cls = CLS_HOOK;
        end else if (tok_sum.cnt_is5 && !tok_sum.kw_miss[1]) begin
            res.cls = CLS_CHOOK;
        end else if (tok_sum.cnt_gt1 && all_al && all_up) begin
            res.cls = CLS_DKEY;
        end else if (tok_sum.cnt_gt1 && all_al && all_lo) begin
            res.cls = CLS_IKEY;
        end else if (tok_sum.first_char == CH_AT && tail_an) begin
            res.cls  = CLS_MAP;
            res.skip = 1'b1;
            res.trim = 2'd1;
        end else if (tok_sum.first_char == CH_LBRACE && tok_sum.last_char == CH_RBRACE) begin
            res.cls  = CLS_INCLUDE;
            res.skip = 1'b1;
            res.trim = 2'd2;
        end
    end

endmodule

[hdl/token_class_lexer_core.sv]
// Top level of the token class lexer: input register, token tracking, result register.
//
// Source bytes come in on the s_ stream, one byte per transaction, with s_tlast on
// the final byte of a source. A space or newline ends the pending token; the last
// byte ends it too. Each closed token yields one m_ transaction whose m_tuser holds
// its class (0 cell, 1 phase, 2 feed, 3 hook, 4 chook, 5 dependent key,
// 6 independent key, 7 map, 8 include, 9 invalid, 10 none) and whose m_tdata holds
// the payload offset and length after the prefix or brackets are stripped, plus
// the sticky error and offset overflow flags. The s_tlast byte always yields a
// result, with m_tlast set, and returns the block to its reset state. Bytes at or
// beyond offset 2**OFFSET_BITS-1 all sit at that offset and raise the overflow
// flag. Throughput is one byte per clock while the sink keeps up: each byte is taken
// into an input register, and once it moves on, the tracker and classifier update the
// token state and build the result, which is registered in the result register and
// shown on m_. The result register holds a result while the sink stalls and the
// input register keeps taking one more byte meanwhile.
module token_class_lexer_core #(
    parameter int OFFSET_BITS = tcl_pkg::OFFSET_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [7:0] source_byte
    input  logic [tcl_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                          s_tlast,   // end_of_source
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: [15:0] payload_start, [31:16] payload_length, [32] error_seen,
    //          [33] offset_overflow, [39:34] zero
    output logic [tcl_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: [3:0] token_class
    output logic [tcl_pkg::CLASS_W-1:0]   m_tuser,
    output logic                          m_tlast,   // source_done
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import tcl_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              fire;

    // Result register
    logic                 m_valid_reg, m_valid_next;
    logic [CLASS_W-1:0]   cls_reg;
    logic [PAYLOAD_W-1:0] start_reg, len_reg;
    logic                 err_reg, ovf_reg, done_reg;

    tok_sum_t               tok_sum;
    cls_res_t               cls_res;
    logic [OFFSET_BITS-1:0] begin_after, count_after;
    logic                   closing, sticky_err, ovf_flag;
    logic                   tok_invalid, emit;

    logic [OFFSET_BITS-1:0]           start_full, len_full;
    logic [PAYLOAD_W+OFFSET_BITS-1:0] start_ext, len_ext;
    logic [CLASS_W-1:0]               cls_out;

    // A byte moves out of the input register when the result slot is free or drains
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tcl_track #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .byte_in    (in_byte_reg),
        .last_in    (in_last_reg),
        .tok_invalid(tok_invalid),
        .tok_sum    (tok_sum),
        .begin_after(begin_after),
        .count_after(count_after),
        .closing    (closing),
        .sticky_err (sticky_err),
        .ovf_flag   (ovf_flag)
    );

    tcl_classify u_classify (
        .tok_sum(tok_sum),
        .res    (cls_res)
    );

    assign tok_invalid = (cls_res.cls == CLS_INVALID);
    assign emit        = closing || in_last_reg;

    // Payload window; start saturates at the top offset, output keeps the low bits
    always_comb begin
        if (!closing) begin
            cls_out    = CLS_NONE;
            start_full = '0;
            len_full   = '0;
        end else begin
            cls_out = cls_res.cls;
            if (cls_res.skip) begin
                start_full = (begin_after == OFF_MAX) ? OFF_MAX : begin_after + 1'b1;
            end else begin
                start_full = begin_after;
            end
            len_full = count_after - OFFSET_BITS'(cls_res.trim);
        end
        start_ext = {{PAYLOAD_W{1'b0}}, start_full};
        len_ext   = {{PAYLOAD_W{1'b0}}, len_full};
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            cls_reg   <= cls_out;
            start_reg <= start_ext[PAYLOAD_W-1:0];
            len_reg   <= len_ext[PAYLOAD_W-1:0];
            err_reg   <= sticky_err;
            ovf_reg   <= ovf_flag;
            done_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = cls_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*PAYLOAD_W - 2){1'b0}}, ovf_reg, err_reg,
                       len_reg, start_reg};

    // Class "none" only comes from the end-of-source byte
    a_none_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CLS_NONE) |-> m_tlast)
        else $error("class none reported on a result that does not end the source");

    // An invalid token always shows in the sticky error flag of its own result
    a_invalid_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CLS_INVALID) |-> m_tdata[2*PAYLOAD_W])
        else $error("invalid token reported without error flag");

    // Fixed-length classes carry their exact lengths
    a_fixed_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == CLS_PHASE) || (m_tuser == CLS_HOOK)
                  || (m_tuser == CLS_CHOOK))
        |-> (m_tdata[2*PAYLOAD_W-1:PAYLOAD_W] == ((m_tuser == CLS_PHASE) ? 16'd1 :
             (m_tuser == CLS_HOOK) ? 16'd4 : 16'd5)))
        else $error("phase or keyword token with a wrong payload length");

    // The sticky error flag is cleared after an end-of-source byte is processed
    a_reset_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> !sticky_err || closing)
        else $error("sticky error survived the end of a source");

endmodule
